@@ design/tltm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table map: shared definitions
// Index widths, field positions, operation codes and default sizes.
// ----------------------------------------------------------------------------
package tltm_pkg;

	localparam int IDX_W           = 10;
	localparam int DIR_ENTRIES     = 1024;
	localparam int TBL_ENTRIES     = 1024;
	localparam int DIR_LSB         = 22;
	localparam int TBL_LSB         = 12;
	localparam int FRAME_LSB       = 12;
	localparam int ADDR_W          = 32;
	localparam int ENTRY_W         = 32;
	localparam int FLAGS_W         = 12;
	localparam int FUNC_W          = 2;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int TBL_DEPTH_DEF   = TABLE_SLOTS_DEF * TBL_ENTRIES;
	localparam int TBL_ADDR_W_DEF  = $clog2(TBL_DEPTH_DEF);

	localparam logic [FUNC_W-1:0] FUNC_MAP    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UNMAP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

endpackage

@@ design/tltm_tbl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table map: table store
// Single-port synchronous RAM holding the pool tables, with a registered read.
// ----------------------------------------------------------------------------
module tltm_tbl_ram #(
	parameter int DEPTH  = tltm_pkg::TBL_DEPTH_DEF,
	parameter int ADDR_W = tltm_pkg::TBL_ADDR_W_DEF,
	parameter int DATA_W = tltm_pkg::ENTRY_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/two_level_page_table_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table map
// Map, unmap and lookup of 4 KiB page entries through a directory and a pool
// of tables held in synchronous memories.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   req_valid/req_stall   func, virt_addr, phys_addr, entry_flags
//  response  rsp_valid/rsp_stall   entry, status
//
// A request does a directory read, then a table write (map, unmap) or a
// table read (lookup), each through a registered memory port.
// A map that claims a new table clears that table one entry per cycle
// through the single table RAM port.
// After reset all 1024 directory entries are cleared with req_stall high.
// A result that cannot transfer is held in a pending register; no new
// request is taken until it has moved to the response register.
module two_level_page_table_map #(
	parameter int TABLE_SLOTS = tltm_pkg::TABLE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tltm_pkg::FUNC_W-1:0]   func,
	input  logic [tltm_pkg::ADDR_W-1:0]   virt_addr,
	input  logic [tltm_pkg::ADDR_W-1:0]   phys_addr,
	input  logic [tltm_pkg::FLAGS_W-1:0]  entry_flags,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [tltm_pkg::ENTRY_W-1:0]  entry,
	output logic                          status
);
	import tltm_pkg::*;

	localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int DW         = $clog2(TABLE_SLOTS + 1);
	localparam int TBL_DEPTH  = TABLE_SLOTS * TBL_ENTRIES;
	localparam int TBL_ADDR_W = SLOT_W + IDX_W;
	localparam logic [IDX_W-1:0] CNT_LAST   = IDX_W'(TBL_ENTRIES - 1);
	localparam logic [DW-1:0]    POOL_LIMIT = DW'(TABLE_SLOTS);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIR   = 6'b000100,
		S_ZERO  = 6'b001000,
		S_TRD   = 6'b010000,
		S_PEND  = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     cnt_q;
	logic [DW-1:0]        used_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [FUNC_W-1:0]    func_q;
	logic [IDX_W-1:0]     dir_idx_q;
	logic [IDX_W-1:0]     tbl_idx_q;
	logic [ENTRY_W-1:0]   new_entry_q;
	logic [ENTRY_W-1:0]   pend_entry_q;
	logic                 pend_status_q;
	logic                 rsp_valid_q;
	logic [ENTRY_W-1:0]   entry_q;
	logic                 status_q;

	logic [DW-1:0]        dir_mem [DIR_ENTRIES];
	logic [DW-1:0]        dir_rd_q;
	logic                 dir_we;
	logic [IDX_W-1:0]     dir_waddr;
	logic [DW-1:0]        dir_wdata;

	logic                 t_we;
	logic [TBL_ADDR_W-1:0] t_addr;
	logic [ENTRY_W-1:0]   t_wdata;
	logic [ENTRY_W-1:0]   t_rdata;

	logic                 req_fire;
	logic                 has_tbl;
	logic                 pool_full;
	logic [SLOT_W-1:0]    cur_slot;
	logic                 alloc;
	logic                 res_done;
	logic [ENTRY_W-1:0]   res_entry;
	logic                 res_status;
	logic                 out_free;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign has_tbl   = (dir_rd_q != '0);
	assign pool_full = (used_q == POOL_LIMIT);
	assign cur_slot  = SLOT_W'(dir_rd_q - DW'(1));
	assign alloc     = (state_q == S_DIR) && (func_q == FUNC_MAP) && !has_tbl && !pool_full;

	assign dir_we    = (state_q == S_CLEAR) || alloc;
	assign dir_waddr = (state_q == S_CLEAR) ? cnt_q : dir_idx_q;
	assign dir_wdata = (state_q == S_CLEAR) ? '0 : DW'(used_q + DW'(1));

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rd_q <= dir_mem[virt_addr[DIR_LSB +: IDX_W]];
	end

	always_comb begin
		t_we    = 1'b0;
		t_addr  = {cur_slot, tbl_idx_q};
		t_wdata = '0;
		if (state_q == S_DIR) begin
			t_we    = has_tbl && ((func_q == FUNC_MAP) || (func_q == FUNC_UNMAP));
			t_wdata = (func_q == FUNC_MAP) ? new_entry_q : '0;
		end else if (state_q == S_ZERO) begin
			t_we    = 1'b1;
			t_addr  = {slot_q, cnt_q};
			t_wdata = (cnt_q == tbl_idx_q) ? new_entry_q : '0;
		end
	end

	tltm_tbl_ram #(
		.DEPTH  (TBL_DEPTH),
		.ADDR_W (TBL_ADDR_W),
		.DATA_W (ENTRY_W)
	) u_tbl_ram (
		.clk   (clk),
		.we    (t_we),
		.addr  (t_addr),
		.wdata (t_wdata),
		.rdata (t_rdata)
	);

	always_comb begin
		state_d    = state_q;
		res_done   = 1'b0;
		res_entry  = '0;
		res_status = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == CNT_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				if (alloc) begin
					state_d = S_ZERO;
				end else if ((func_q == FUNC_LOOKUP) && has_tbl) begin
					state_d = S_TRD;
				end else begin
					res_done   = 1'b1;
					res_status = (func_q == FUNC_MAP) && !has_tbl && pool_full;
				end
			end
			S_ZERO: begin
				res_done = (cnt_q == CNT_LAST);
			end
			S_TRD: begin
				res_done  = 1'b1;
				res_entry = t_rdata;
			end
			S_PEND: begin
				res_done   = 1'b1;
				res_entry  = pend_entry_q;
				res_status = pend_status_q;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (res_done) begin
			state_d = out_free ? S_IDLE : S_PEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_CLEAR) || (state_q == S_ZERO)) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (alloc) begin
				used_q <= used_q + DW'(1);
			end
			if (res_done && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q      <= func;
			dir_idx_q   <= virt_addr[DIR_LSB +: IDX_W];
			tbl_idx_q   <= virt_addr[TBL_LSB +: IDX_W];
			new_entry_q <= {phys_addr[ADDR_W-1:FRAME_LSB], entry_flags};
		end
		if (alloc) begin
			slot_q <= SLOT_W'(used_q);
		end
		if (res_done && !out_free) begin
			pend_entry_q  <= res_entry;
			pend_status_q <= res_status;
		end
		if (res_done && out_free) begin
			entry_q  <= res_entry;
			status_q <= res_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign entry     = entry_q;
	assign status    = status_q;

endmodule

@@ design/tltm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table map: port checker
// Concurrent assertions on the ports of the top level, bound to it.
// ----------------------------------------------------------------------------
module tltm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [tltm_pkg::ENTRY_W-1:0] entry,
	input logic                         status
);

	// A stalled response keeps its transfer pending and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(entry) && $stable(status))
		else $error("stalled response changed");

	// A refused map never reports an entry.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> entry == '0)
		else $error("refused map carries a non-zero entry");

	// Requests are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	// A new response only appears while the engine is busy with its request.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without work in progress");

endmodule

bind two_level_page_table_map tltm_checker u_tltm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.entry     (entry),
	.status    (status)
);
